/* src/pgm_pkg.sv */
package pgm_pkg;

  localparam int CFG_IDX_W    = 3;
  localparam int P_BITS       = 44;  // momentum magnitude quotient
  localparam int N_BITS       = 20;  // normalized direction component
  localparam int SUM_BITS     = 42;  // sum of squares
  localparam int ROOT_BITS    = 21;  // floor sqrt of the sum
  localparam int PROD_BITS    = P_BITS + N_BITS;
  localparam int FRONT_STAGES = 8;
  localparam int SCALE_STAGES = 2 + P_BITS + 1;
  localparam int LATENCY      = P_BITS + FRONT_STAGES + ROOT_BITS + SCALE_STAGES;

  localparam logic [CFG_IDX_W-1:0] REG_U_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_U_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_U_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_V_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_V_Z = 3'd5;

  localparam logic [15:0] AXIS_ONE  = 16'h4000;
  localparam logic [15:0] AXIS_ZERO = 16'h0000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_QZERO = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] q_over_p;
    logic signed [31:0] slope_u;
    logic signed [31:0] slope_v;
    logic signed [31:0] offset_u;
    logic signed [31:0] offset_v;
    logic signed [3:0]  particle_charge;
    logic               along_normal;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
  } pgm_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic [1:0]         status;
  } pgm_out_t;

  typedef struct packed {
    logic [2:0][15:0] u;
    logic [2:0][15:0] v;
    logic [2:0][32:0] w;
  } pgm_axes_t;

  typedef struct packed {
    logic [2:0][31:0]       pos;
    logic [2:0][N_BITS-1:0] n;
    logic [2:0]             a_neg;
    logic                   base_neg;
    logic                   qzero;
    logic                   czero;
    logic [P_BITS-1:0]      p;
  } pgm_ctx_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0]       a_neg;
    logic             base_neg;
    logic             qzero;
    logic             zero;
  } pgm_fin_t;

endpackage

/* src/pgm_divpipe.sv */
module pgm_divpipe #(
  parameter int LN = 1,
  parameter int DW = 32,
  parameter int QW = 44,
  parameter int PW = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [LN-1:0][DW-1:0]  in_rem,
  input  logic [LN-1:0][QW-1:0]  in_num,
  input  logic [DW-1:0]          in_den,
  input  logic [PW-1:0]          in_pay,
  output logic                   out_vld,
  output logic [LN-1:0][QW-1:0]  out_quo,
  output logic [PW-1:0]          out_pay
);

  logic [LN-1:0][DW-1:0] rem_r [QW];
  logic [LN-1:0][QW-1:0] num_r [QW];
  logic [DW-1:0]         den_r [QW];
  logic [PW-1:0]         pay_r [QW];
  logic [QW-1:0]         vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QW-2:0], in_vld};
    end
  end

  // one restoring step per stage; quotient bits shift in behind the dividend
  for (genvar k = 0; k < QW; k++) begin : g_stg
    logic [LN-1:0][DW-1:0] rem_src, rem_nxt;
    logic [LN-1:0][QW-1:0] num_src, num_nxt;
    logic [DW-1:0]         den_src;
    logic [PW-1:0]         pay_src;

    if (k == 0) begin : g_first
      assign rem_src = in_rem;
      assign num_src = in_num;
      assign den_src = in_den;
      assign pay_src = in_pay;
    end else begin : g_next
      assign rem_src = rem_r[k-1];
      assign num_src = num_r[k-1];
      assign den_src = den_r[k-1];
      assign pay_src = pay_r[k-1];
    end

    always_comb begin
      logic [DW:0] sh;
      for (int l = 0; l < LN; l++) begin
        sh = {rem_src[l], num_src[l][QW-1]};
        if (sh >= {1'b0, den_src}) begin
          rem_nxt[l] = DW'(sh - {1'b0, den_src});
          num_nxt[l] = {num_src[l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = sh[DW-1:0];
          num_nxt[l] = {num_src[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      num_r[k] <= num_nxt;
      den_r[k] <= den_src;
      pay_r[k] <= pay_src;
    end
  end

  assign out_vld = vld_r[QW-1];
  assign out_quo = num_r[QW-1];
  assign out_pay = pay_r[QW-1];

endmodule

/* src/pgm_front.sv */
module pgm_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  pgm_pkg::pgm_in_t             in_item,
  input  logic [pgm_pkg::P_BITS-1:0]   in_p,
  input  pgm_pkg::pgm_axes_t           axes,
  output logic                         out_vld,
  output pgm_pkg::pgm_ctx_t            out_ctx,
  output logic [pgm_pkg::SUM_BITS-1:0] out_sum
);

  typedef struct packed {
    logic [2:0][31:0]           org;
    logic                       bneg;
    logic                       qz;
    logic                       cz;
    logic [pgm_pkg::P_BITS-1:0] p;
  } pgm_hd_t;

  logic [pgm_pkg::FRONT_STAGES-1:0] vld_r;

  logic signed [47:0] pu_r [3];
  logic signed [47:0] pv_r [3];
  logic signed [47:0] du_r [3];
  logic signed [47:0] dv_r [3];
  pgm_hd_t            hd1_nxt, hd1_r, hd2_r;
  logic [48:0]        t_r [3];
  logic [49:0]        a_r [3];
  pgm_pkg::pgm_ctx_t  c3_nxt, c3_r, c4_r, c5_r, c6_nxt, c6_r, c7_r, c8_r;
  logic [49:0]        mag3_nxt [3];
  logic [49:0]        mag3_r [3];
  logic [49:0]        mag4_r [3];
  logic [49:0]        mag5_r [3];
  logic [49:0]        mx4_nxt, mx4_r;
  logic [5:0]         s5_nxt, s5_r;
  logic [2*pgm_pkg::N_BITS-1:0] sq7_r [3];
  logic [pgm_pkg::SUM_BITS-1:0] sum8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[pgm_pkg::FRONT_STAGES-2:0], in_vld};
    end
  end

  // stage 1: products against the plane axes
  always_comb begin
    hd1_nxt.org  = {in_item.origin_z, in_item.origin_y, in_item.origin_x};
    hd1_nxt.bneg = (in_item.particle_charge[3] ^ in_item.q_over_p[31]) ^ !in_item.along_normal;
    hd1_nxt.qz   = (in_item.q_over_p == 32'sd0);
    hd1_nxt.cz   = (in_item.particle_charge == 4'sd0);
    hd1_nxt.p    = in_p;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pu_r[i] <= 48'(in_item.offset_u) * 48'($signed(axes.u[i]));
      pv_r[i] <= 48'(in_item.offset_v) * 48'($signed(axes.v[i]));
      du_r[i] <= 48'(in_item.slope_u) * 48'($signed(axes.u[i]));
      dv_r[i] <= 48'(in_item.slope_v) * 48'($signed(axes.v[i]));
    end
    hd1_r <= hd1_nxt;
  end

  // stage 2: position sum with rounding bias, direction sum
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t_r[i] <= {pu_r[i][47], pu_r[i]} + {pv_r[i][47], pv_r[i]} + 49'd8192;
      a_r[i] <= {{15{axes.w[i][32]}}, axes.w[i], 2'b00}
              + {{2{du_r[i][47]}}, du_r[i]} + {{2{dv_r[i][47]}}, dv_r[i]};
    end
    hd2_r <= hd1_r;
  end

  // stage 3: floor shift, origin add with saturation, magnitudes
  always_comb begin
    logic [48:0] rsh;
    logic [35:0] s36;
    c3_nxt          = '0;
    c3_nxt.base_neg = hd2_r.bneg;
    c3_nxt.qzero    = hd2_r.qz;
    c3_nxt.czero    = hd2_r.cz;
    c3_nxt.p        = hd2_r.p;
    for (int i = 0; i < 3; i++) begin
      rsh = 49'($signed(t_r[i]) >>> 14);
      s36 = {{4{hd2_r.org[i][31]}}, hd2_r.org[i]} + {rsh[34], rsh[34:0]};
      if ((&s36[35:31]) || !(|s36[35:31])) begin
        c3_nxt.pos[i] = s36[31:0];
      end else begin
        c3_nxt.pos[i] = s36[35] ? pgm_pkg::Q_MIN : pgm_pkg::Q_MAX;
      end
      c3_nxt.a_neg[i] = a_r[i][49];
      mag3_nxt[i] = a_r[i][49] ? (~a_r[i] + 50'd1) : a_r[i];
    end
  end

  always_ff @(posedge clk) begin
    c3_r   <= c3_nxt;
    mag3_r <= mag3_nxt;
  end

  // stage 4: largest magnitude
  always_comb begin
    mx4_nxt = mag3_r[0];
    if (mag3_r[1] > mx4_nxt) mx4_nxt = mag3_r[1];
    if (mag3_r[2] > mx4_nxt) mx4_nxt = mag3_r[2];
  end

  always_ff @(posedge clk) begin
    mx4_r  <= mx4_nxt;
    mag4_r <= mag3_r;
    c4_r   <= c3_r;
  end

  // stage 5: shift that brings the largest below 2^N_BITS
  always_comb begin
    logic [5:0] bl;
    bl = '0;
    for (int i = 0; i < 50; i++) begin
      if (mx4_r[i]) bl = 6'(i + 1);
    end
    s5_nxt = (bl > 6'(pgm_pkg::N_BITS)) ? 6'(bl - 6'(pgm_pkg::N_BITS)) : 6'd0;
  end

  always_ff @(posedge clk) begin
    s5_r   <= s5_nxt;
    mag5_r <= mag4_r;
    c5_r   <= c4_r;
  end

  // stage 6: normalized components
  always_comb begin
    c6_nxt = c5_r;
    for (int i = 0; i < 3; i++) begin
      c6_nxt.n[i] = pgm_pkg::N_BITS'(mag5_r[i] >> s5_r);
    end
  end

  always_ff @(posedge clk) begin
    c6_r <= c6_nxt;
  end

  // stage 7: squares; stage 8: sum
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq7_r[i] <= (2*pgm_pkg::N_BITS)'(c6_r.n[i]) * (2*pgm_pkg::N_BITS)'(c6_r.n[i]);
    end
    c7_r   <= c6_r;
    sum8_r <= pgm_pkg::SUM_BITS'(sq7_r[0]) + pgm_pkg::SUM_BITS'(sq7_r[1])
            + pgm_pkg::SUM_BITS'(sq7_r[2]);
    c8_r   <= c7_r;
  end

  assign out_vld = vld_r[pgm_pkg::FRONT_STAGES-1];
  assign out_ctx = c8_r;
  assign out_sum = sum8_r;

endmodule

/* src/pgm_sqrt.sv */
module pgm_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [pgm_pkg::SUM_BITS-1:0]  in_x,
  input  pgm_pkg::pgm_ctx_t             in_ctx,
  output logic                          out_vld,
  output logic [pgm_pkg::ROOT_BITS-1:0] out_root,
  output pgm_pkg::pgm_ctx_t             out_ctx
);

  localparam int RB = pgm_pkg::ROOT_BITS;
  localparam int XB = pgm_pkg::SUM_BITS;

  logic [XB-1:0]     rem_r  [RB];
  logic [RB-1:0]     root_r [RB];
  pgm_pkg::pgm_ctx_t ctx_r  [RB];
  logic [RB-1:0]     vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[RB-2:0], in_vld};
    end
  end

  // stage j decides root bit RB-1-j; rem holds x - root^2
  for (genvar j = 0; j < RB; j++) begin : g_stg
    localparam int K = RB - 1 - j;
    logic [XB-1:0]     rem_src, rem_nxt;
    logic [RB-1:0]     root_src, root_nxt;
    pgm_pkg::pgm_ctx_t ctx_src;

    if (j == 0) begin : g_first
      assign rem_src  = in_x;
      assign root_src = '0;
      assign ctx_src  = in_ctx;
    end else begin : g_next
      assign rem_src  = rem_r[j-1];
      assign root_src = root_r[j-1];
      assign ctx_src  = ctx_r[j-1];
    end

    always_comb begin
      logic [XB:0] trial;
      trial = ((XB+1)'(root_src) << (K + 1)) + ((XB+1)'(1) << (2 * K));
      if ({1'b0, rem_src} >= trial) begin
        rem_nxt  = XB'({1'b0, rem_src} - trial);
        root_nxt = root_src | (RB'(1) << K);
      end else begin
        rem_nxt  = rem_src;
        root_nxt = root_src;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= rem_nxt;
      root_r[j] <= root_nxt;
      ctx_r[j]  <= ctx_src;
    end
  end

  assign out_vld  = vld_r[RB-1];
  assign out_root = root_r[RB-1];
  assign out_ctx  = ctx_r[RB-1];

endmodule

/* src/pgm_scale.sv */
module pgm_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  pgm_pkg::pgm_ctx_t             in_ctx,
  input  logic [pgm_pkg::ROOT_BITS-1:0] in_root,
  output logic                          out_strobe,
  output pgm_pkg::pgm_out_t             out_data
);

  localparam int PB = pgm_pkg::P_BITS;
  localparam int NB = pgm_pkg::N_BITS;
  localparam int RB = pgm_pkg::ROOT_BITS;
  localparam int XB = pgm_pkg::PROD_BITS;
  localparam int HB = PB / 2;
  localparam int LB = PB - HB;
  localparam int FW = $bits(pgm_pkg::pgm_fin_t);

  logic [1:0]             vld_r;
  logic [HB+NB-1:0]       hi_r [3];
  logic [LB+NB-1:0]       lo_r [3];
  logic [XB-1:0]          prod_r [3];
  pgm_pkg::pgm_fin_t      fin1_nxt, fin1_r, fin2_r, fin_q;
  logic [RB-1:0]          root1_r, root2_r;
  logic [2:0][RB-1:0]     dv_rem;
  logic [2:0][PB-1:0]     dv_num, dv_quo;
  logic [FW-1:0]          dv_pay;
  logic                   dv_vld;
  pgm_pkg::pgm_out_t      out_nxt, out_r;
  logic                   strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[0], in_vld};
    end
  end

  always_comb begin
    fin1_nxt.pos      = in_ctx.pos;
    fin1_nxt.a_neg    = in_ctx.a_neg;
    fin1_nxt.base_neg = in_ctx.base_neg;
    fin1_nxt.qzero    = in_ctx.qzero;
    fin1_nxt.zero     = in_ctx.czero || (in_root == '0);
  end

  // P * n in two partial products, then recombined
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      hi_r[i]   <= (HB+NB)'(in_ctx.p[PB-1:LB]) * (HB+NB)'(in_ctx.n[i]);
      lo_r[i]   <= (LB+NB)'(in_ctx.p[LB-1:0]) * (LB+NB)'(in_ctx.n[i]);
      prod_r[i] <= {hi_r[i], {LB{1'b0}}} + XB'(lo_r[i]);
    end
    fin1_r  <= fin1_nxt;
    root1_r <= in_root;
    fin2_r  <= fin1_r;
    root2_r <= root1_r;
  end

  // quotient stays below 2^PB since n never exceeds the root
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[i] = RB'(prod_r[i][XB-1:PB]);
      dv_num[i] = prod_r[i][PB-1:0];
    end
  end

  pgm_divpipe #(
    .LN (3),
    .DW (RB),
    .QW (PB),
    .PW (FW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_r[1]),
    .in_rem  (dv_rem),
    .in_num  (dv_num),
    .in_den  (root2_r),
    .in_pay  (fin2_r),
    .out_vld (dv_vld),
    .out_quo (dv_quo),
    .out_pay (dv_pay)
  );

  assign fin_q = pgm_pkg::pgm_fin_t'(dv_pay);

  always_comb begin
    logic [2:0][31:0] mom;
    logic             sat;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (fin_q.base_neg ^ fin_q.a_neg[i]) begin
        if (dv_quo[i] > PB'(pgm_pkg::Q_MIN)) begin
          mom[i] = pgm_pkg::Q_MIN;
          sat    = 1'b1;
        end else begin
          mom[i] = ~dv_quo[i][31:0] + 32'd1;
        end
      end else begin
        if (dv_quo[i] > PB'(pgm_pkg::Q_MAX)) begin
          mom[i] = pgm_pkg::Q_MAX;
          sat    = 1'b1;
        end else begin
          mom[i] = dv_quo[i][31:0];
        end
      end
    end
    out_nxt.pos_x = fin_q.pos[0];
    out_nxt.pos_y = fin_q.pos[1];
    out_nxt.pos_z = fin_q.pos[2];
    if (fin_q.qzero || fin_q.zero) begin
      out_nxt.mom_x  = '0;
      out_nxt.mom_y  = '0;
      out_nxt.mom_z  = '0;
      out_nxt.status = fin_q.qzero ? pgm_pkg::ST_QZERO : pgm_pkg::ST_OK;
    end else begin
      out_nxt.mom_x  = mom[0];
      out_nxt.mom_y  = mom[1];
      out_nxt.mom_z  = mom[2];
      out_nxt.status = sat ? pgm_pkg::ST_SAT : pgm_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

/* src/plane_state_to_global_pos_mom.sv */
// Track state on a plane to global position and momentum.
//
// Input: raise start with a word on in_data; the word is taken at any edge
// where start is high and busy is low. busy stays low, so one word can be
// taken every cycle.
// Output: each result word sits on out_data for one cycle with out_strobe
// high, in input order. The receiver has no way to stall; words are never
// held back. A word passes, in order, the momentum divider, the front pipe,
// the square root, the product stage, the scale divider and the output
// register.
// Config: cfg_valid/cfg_ready write the plane axes U (index 0..2) and
// V (index 3..5), Q1.14; other indexes are dropped. cfg_ready is always
// high. Write axes only while no word is in flight.
// Reset: rst_n low clears the pipe and sets U = (1,0,0), V = (0,1,0).
module plane_state_to_global_pos_mom (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  pgm_pkg::pgm_in_t                 in_data,
  output logic                             out_strobe,
  output pgm_pkg::pgm_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pgm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data
);

  localparam int PB = pgm_pkg::P_BITS;
  localparam int IW = $bits(pgm_pkg::pgm_in_t);

  logic [15:0]        cfg_u_r [3];
  logic [15:0]        cfg_v_r [3];
  logic signed [32:0] w_r [3];
  pgm_pkg::pgm_axes_t axes;

  logic               acc;
  logic [3:0]         cm;
  logic [31:0]        qm;
  logic [0:0][31:0]   pd_rem, pd_den_l;
  logic [0:0][PB-1:0] pd_num, pd_quo;
  logic [IW-1:0]      pd_pay;
  logic               pd_vld;

  logic                         fr_vld;
  pgm_pkg::pgm_ctx_t            fr_ctx;
  logic [pgm_pkg::SUM_BITS-1:0] fr_sum;

  logic                          sq_vld;
  logic [pgm_pkg::ROOT_BITS-1:0] sq_root;
  pgm_pkg::pgm_ctx_t             sq_ctx;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_u_r[0] <= pgm_pkg::AXIS_ONE;
      cfg_u_r[1] <= pgm_pkg::AXIS_ZERO;
      cfg_u_r[2] <= pgm_pkg::AXIS_ZERO;
      cfg_v_r[0] <= pgm_pkg::AXIS_ZERO;
      cfg_v_r[1] <= pgm_pkg::AXIS_ONE;
      cfg_v_r[2] <= pgm_pkg::AXIS_ZERO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pgm_pkg::REG_U_X: cfg_u_r[0] <= cfg_data;
        pgm_pkg::REG_U_Y: cfg_u_r[1] <= cfg_data;
        pgm_pkg::REG_U_Z: cfg_u_r[2] <= cfg_data;
        pgm_pkg::REG_V_X: cfg_v_r[0] <= cfg_data;
        pgm_pkg::REG_V_Y: cfg_v_r[1] <= cfg_data;
        pgm_pkg::REG_V_Z: cfg_v_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // W = U x V, Q4.28
  always_ff @(posedge clk) begin
    w_r[0] <= 33'($signed(cfg_u_r[1])) * 33'($signed(cfg_v_r[2]))
            - 33'($signed(cfg_u_r[2])) * 33'($signed(cfg_v_r[1]));
    w_r[1] <= 33'($signed(cfg_u_r[2])) * 33'($signed(cfg_v_r[0]))
            - 33'($signed(cfg_u_r[0])) * 33'($signed(cfg_v_r[2]));
    w_r[2] <= 33'($signed(cfg_u_r[0])) * 33'($signed(cfg_v_r[1]))
            - 33'($signed(cfg_u_r[1])) * 33'($signed(cfg_v_r[0]));
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      axes.u[i] = cfg_u_r[i];
      axes.v[i] = cfg_v_r[i];
      axes.w[i] = w_r[i];
    end
  end

  // |c| * 2^40 / |q|
  assign cm = in_data.particle_charge[3] ? (~in_data.particle_charge + 4'd1)
                                         : in_data.particle_charge;
  assign qm = in_data.q_over_p[31] ? (~in_data.q_over_p + 32'd1) : in_data.q_over_p;
  assign pd_rem[0]   = '0;
  assign pd_num[0]   = {cm, {(PB-4){1'b0}}};
  assign pd_den_l[0] = qm;

  pgm_divpipe #(
    .LN (1),
    .DW (32),
    .QW (PB),
    .PW (IW)
  ) u_pdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc),
    .in_rem  (pd_rem),
    .in_num  (pd_num),
    .in_den  (pd_den_l[0]),
    .in_pay  (in_data),
    .out_vld (pd_vld),
    .out_quo (pd_quo),
    .out_pay (pd_pay)
  );

  pgm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (pd_vld),
    .in_item (pgm_pkg::pgm_in_t'(pd_pay)),
    .in_p    (pd_quo[0]),
    .axes    (axes),
    .out_vld (fr_vld),
    .out_ctx (fr_ctx),
    .out_sum (fr_sum)
  );

  pgm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_x     (fr_sum),
    .in_ctx   (fr_ctx),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_ctx  (sq_ctx)
  );

  pgm_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (sq_vld),
    .in_ctx     (sq_ctx),
    .in_root    (sq_root),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  a_strobe_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(acc, pgm_pkg::LATENCY))
    else $error("result word without matching input word");

  a_accept_to_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##(pgm_pkg::LATENCY) (out_strobe || !$past(rst_n, pgm_pkg::LATENCY - 1)))
    else $error("input word lost in pipe");

  a_qzero_mom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == pgm_pkg::ST_QZERO) |->
      (out_data.mom_x == 32'sd0 && out_data.mom_y == 32'sd0 && out_data.mom_z == 32'sd0))
    else $error("zero q/p with nonzero momentum");

  a_sat_mom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == pgm_pkg::ST_SAT) |->
      (out_data.mom_x == pgm_pkg::Q_MAX || out_data.mom_x == pgm_pkg::Q_MIN ||
       out_data.mom_y == pgm_pkg::Q_MAX || out_data.mom_y == pgm_pkg::Q_MIN ||
       out_data.mom_z == pgm_pkg::Q_MAX || out_data.mom_z == pgm_pkg::Q_MIN))
    else $error("saturation flagged without a clamped component");

endmodule
